/* design/frli_pkg.sv */
// Package: shared constants and types for the flash record log index.
`default_nettype none
package frli_pkg;
	localparam int FILES_DEF = 10;
	localparam int BLOCKS_DEF = 3;
	localparam int SLOTS_DEF = 512;
	localparam int BLOCK_BYTES_DEF = 65536;
	localparam int RECORD_BYTES_DEF = 128;
	localparam logic [31:0] REGION_BASE_RST = 32'h0060_0000;

	localparam logic [1:0] KIND_SCAN = 2'd0;
	localparam logic [1:0] KIND_COMMIT = 2'd1;
	localparam logic [1:0] KIND_WRITE = 2'd2;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_EMPTY = 3'd1;
	localparam logic [2:0] ST_UNMOUNTED = 3'd2;
	localparam logic [2:0] ST_BADFILE = 3'd3;
	localparam logic [2:0] ST_SCAN = 3'd4;

	typedef struct packed {
		logic [1:0] kind;
		logic [3:0] file_id;
		logic [1:0] scan_block;
		logic [8:0] scan_slot;
		logic record_valid;
		logic [31:0] record_sn;
	} frli_item_t;
endpackage
`default_nettype wire

/* design/frli_front.sv */
// Front end: accept commands into a two-entry queue.
`default_nettype none
module frli_front import frli_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire frli_item_t push_item,
	input wire logic pop,
	output logic full,
	output logic avail,
	output frli_item_t head
);
	frli_item_t mem_q [2];
	logic wr_q, rd_q;
	logic [1:0] cnt_q;

	assign full = cnt_q == 2'd2;
	assign avail = cnt_q != 2'd0;
	assign head = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule
`default_nettype wire

/* design/frli_back.sv */
// Back end: scan state, pointer table, commit and write execution.
`default_nettype none
module frli_back import frli_pkg::*; #(
	parameter int FILES = FILES_DEF,
	parameter int BLOCKS = BLOCKS_DEF,
	parameter int SLOTS = SLOTS_DEF,
	parameter int BLOCK_BYTES = BLOCK_BYTES_DEF,
	parameter int RECORD_BYTES = RECORD_BYTES_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic [31:0] region_base,
	input wire logic avail,
	input wire frli_item_t head,
	output logic pop,
	output logic done,
	output logic [2:0] status,
	output logic [1:0] rec_block,
	output logic [8:0] rec_slot,
	output logic [31:0] flash_address,
	output logic erase_first,
	output logic [31:0] stamp_sn
);
	localparam int SW = $clog2(SLOTS);
	localparam int BW = $clog2(BLOCKS);
	localparam int FW = (FILES > 1) ? $clog2(FILES) : 1;
	localparam logic [31:0] FILE_BYTES = 32'(BLOCKS * BLOCK_BYTES);

	logic mnt_q [FILES];
	logic [31:0] psn_q [FILES];
	logic [BW-1:0] pblk_q [FILES];
	logic [SW-1:0] pslot_q [FILES];
	logic hv_q [BLOCKS];
	logic [31:0] fsn_q [BLOCKS];
	logic [SW-1:0] lslot_q [BLOCKS];

	// stage 1 captures decision; stage 2 computes address
	logic v_s1;
	logic [2:0] st_s1;
	logic [BW-1:0] blk_s1;
	logic [SW-1:0] slot_s1;
	logic er_s1;
	logic [31:0] sn_s1;
	logic [31:0] fofs_s1;

	logic [FW-1:0] fi;
	logic fok;
	logic [31:0] big;
	logic [BW-1:0] ch;
	logic chv;
	logic [31:0] nsn;
	logic [BW-1:0] nblk;
	logic [SW-1:0] nslot;
	logic [31:0] asn;
	logic [BW-1:0] ablk;
	logic [SW-1:0] aslot;
	logic [2:0] d_st;
	logic [BW-1:0] d_blk;
	logic [SW-1:0] d_slot;
	logic d_er;
	logic [31:0] d_sn;

	assign pop = avail;
	assign fi = head.file_id[FW-1:0];
	assign fok = 32'(head.file_id) < 32'(FILES);

	always_comb begin
		big = '0;
		for (int i = 0; i < BLOCKS; i++)
			if (hv_q[i] && fsn_q[i] > big) big = fsn_q[i];
		ch = '0;
		chv = 1'b0;
		for (int i = BLOCKS - 1; i >= 0; i--)
			if (hv_q[i] && fsn_q[i] == big) begin
				ch = BW'(i);
				chv = 1'b1;
			end
	end

	// pointer to advance: write uses the table, commit uses the found record
	always_comb begin
		if (head.kind == KIND_COMMIT) begin
			nsn = fsn_q[ch];
			nblk = ch;
			nslot = lslot_q[ch];
		end else begin
			nsn = psn_q[fi];
			nblk = pblk_q[fi];
			nslot = pslot_q[fi];
		end
		if (32'(nslot) + 1 >= 32'(SLOTS)) begin
			aslot = '0;
			asn = nsn + 32'd1;
			ablk = (32'(nblk) + 1 >= 32'(BLOCKS)) ? '0 : nblk + BW'(1);
		end else begin
			aslot = nslot + SW'(1);
			asn = nsn;
			ablk = nblk;
		end
	end

	always_comb begin
		d_st = ST_BADFILE;
		d_blk = '0;
		d_slot = '0;
		d_er = 1'b0;
		d_sn = '0;
		if (fok) begin
			unique case (head.kind)
				KIND_SCAN: d_st = ST_SCAN;
				KIND_COMMIT: begin
					d_blk = ch;
					if (chv) begin
						d_st = ST_OK;
						d_slot = lslot_q[ch];
						d_sn = asn;
					end else begin
						d_st = ST_EMPTY;
					end
				end
				KIND_WRITE: begin
					if (!mnt_q[fi]) begin
						d_st = ST_UNMOUNTED;
					end else begin
						d_st = ST_OK;
						d_blk = pblk_q[fi];
						d_slot = pslot_q[fi];
						d_er = pslot_q[fi] == '0;
						d_sn = psn_q[fi];
					end
				end
				default: d_st = ST_BADFILE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (avail) begin
			fofs_s1 <= 32'(head.file_id) * FILE_BYTES;
			st_s1 <= d_st;
			blk_s1 <= d_blk;
			slot_s1 <= d_slot;
			er_s1 <= d_er;
			sn_s1 <= d_sn;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			for (int f = 0; f < FILES; f++) begin
				mnt_q[f] <= 1'b0;
				psn_q[f] <= '0;
				pblk_q[f] <= '0;
				pslot_q[f] <= '0;
			end
			for (int b = 0; b < BLOCKS; b++) begin
				hv_q[b] <= 1'b0;
				fsn_q[b] <= '0;
				lslot_q[b] <= '0;
			end
		end else begin
			v_s1 <= avail;
			if (avail && fok) begin
				if (head.kind == KIND_SCAN) begin
					if (head.record_valid && 32'(head.scan_block) < 32'(BLOCKS)
							&& 32'(head.scan_slot) < 32'(SLOTS)) begin
						if (!hv_q[head.scan_block[BW-1:0]])
							fsn_q[head.scan_block[BW-1:0]] <= head.record_sn;
						hv_q[head.scan_block[BW-1:0]] <= 1'b1;
						lslot_q[head.scan_block[BW-1:0]] <= head.scan_slot[SW-1:0];
					end
				end else if (head.kind == KIND_COMMIT) begin
					mnt_q[fi] <= 1'b1;
					if (chv) begin
						psn_q[fi] <= asn;
						pblk_q[fi] <= ablk;
						pslot_q[fi] <= aslot;
					end else begin
						psn_q[fi] <= '0;
						pblk_q[fi] <= ch;
						pslot_q[fi] <= '0;
					end
					for (int b = 0; b < BLOCKS; b++) begin
						hv_q[b] <= 1'b0;
						fsn_q[b] <= '0;
						lslot_q[b] <= '0;
					end
				end else if (head.kind == KIND_WRITE && mnt_q[fi]) begin
					psn_q[fi] <= asn;
					pblk_q[fi] <= ablk;
					pslot_q[fi] <= aslot;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			status <= st_s1;
			rec_block <= 2'(blk_s1);
			rec_slot <= 9'(slot_s1);
			erase_first <= er_s1;
			stamp_sn <= sn_s1;
			flash_address <= (st_s1 == ST_OK || st_s1 == ST_EMPTY)
				? region_base + fofs_s1
					+ 32'(blk_s1) * 32'(BLOCK_BYTES)
					+ 32'(slot_s1) * 32'(RECORD_BYTES)
				: '0;
		end
	end
endmodule
`default_nettype wire

/* design/flash_record_log_index.sv */
// Top level: flash record log index, front queue and back executor.
// Path: a command passes through the queue, the decision stage, and the address
// and output register before its result strobe.
// Throughput: one command per cycle; the back end retires a queued command each
// cycle, so busy rises only if the two-entry queue fills. The receiver cannot stall.
// Reset: arst_n clears all pointers to unmounted and the scan state, and
// restores region_base to 0x600000.
`default_nettype none
module flash_record_log_index import frli_pkg::*; #(
	parameter int FILES = FILES_DEF,
	parameter int BLOCKS_PER_FILE = BLOCKS_DEF,
	parameter int SLOTS_PER_BLOCK = SLOTS_DEF,
	parameter int BLOCK_BYTES = BLOCK_BYTES_DEF,
	parameter int RECORD_BYTES = RECORD_BYTES_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic cfg_we,
	input wire logic [31:0] cfg_wdata,
	input wire logic [1:0] kind,
	input wire logic [3:0] file_id,
	input wire logic [1:0] scan_block,
	input wire logic [8:0] scan_slot,
	input wire logic record_valid,
	input wire logic [31:0] record_sn,
	output logic done,
	output logic [2:0] status,
	output logic [1:0] rec_block,
	output logic [8:0] rec_slot,
	output logic [31:0] flash_address,
	output logic erase_first,
	output logic [31:0] stamp_sn
);
	logic [31:0] region_base_q;
	frli_item_t in_item, head;
	logic full, avail, pop, push;

	// hold the region base register; the user must write it only while idle, which the block does not enforce
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_base_q <= REGION_BASE_RST;
		end else if (cfg_we) begin
			region_base_q <= cfg_wdata;
		end
	end

	assign busy = full;
	assign push = start && !full;
	assign in_item = '{kind: kind, file_id: file_id, scan_block: scan_block,
		scan_slot: scan_slot, record_valid: record_valid, record_sn: record_sn};

	frli_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .push_item(in_item),
		.pop(pop), .full(full), .avail(avail), .head(head)
	);

	frli_back #(
		.FILES(FILES), .BLOCKS(BLOCKS_PER_FILE), .SLOTS(SLOTS_PER_BLOCK),
		.BLOCK_BYTES(BLOCK_BYTES), .RECORD_BYTES(RECORD_BYTES)
	) u_back (
		.clk(clk), .arst_n(arst_n), .region_base(region_base_q),
		.avail(avail), .head(head), .pop(pop), .done(done), .status(status),
		.rec_block(rec_block), .rec_slot(rec_slot), .flash_address(flash_address),
		.erase_first(erase_first), .stamp_sn(stamp_sn)
	);
endmodule
`default_nettype wire
